// ===== src/pcpg_pkg.sv =====
package pcpg_pkg;

	// Fixed field widths of the configuration registers and the result item.
	localparam int PIX_W      = 12;
	localparam int KIND_W     = 3;
	localparam int COEF_W     = 9;
	localparam int CTR_W      = 10;
	localparam int STEP_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int PIX_MAX = 2047;
	localparam int PIX_MIN = -2048;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_KIND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_A   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 3'd5;

	// Curve kinds.
	localparam logic [KIND_W-1:0] KIND_LIMACON  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CARDIOID = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ROSE3    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ROSE4    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SPIRAL   = 3'd4;

	// Register values after reset.
	localparam logic [KIND_W-1:0] RST_CURVE_KIND = KIND_LIMACON;
	localparam logic [COEF_W-1:0] RST_RADIUS_A   = 9'd175;
	localparam logic [COEF_W-1:0] RST_OFFSET_B   = 9'd60;
	localparam logic [CTR_W-1:0]  RST_CENTER_X   = 10'd200;
	localparam logic [CTR_W-1:0]  RST_CENTER_Y   = 10'd250;
	localparam logic [STEP_W-1:0] RST_ANGLE_STEP = 16'd374;

	// CORDIC gain and arctangent table, all with 30 fraction bits.
	localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
	localparam int     ATAN_LEN        = 20;
	localparam longint ATAN_Q30 [ATAN_LEN] = '{
		64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
		64'sd33543516,  64'sd16775851,  64'sd8388437,   64'sd4194283,   64'sd2097149,
		64'sd1048576,   64'sd524288,    64'sd262144,    64'sd131072,    64'sd65536,
		64'sd32768,     64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048
	};

	// Rescale a value with 30 fraction bits to frac_bits, rounding half up.
	function automatic longint q30_to_fix(longint v, int frac_bits);
		longint half;
		half = longint'(1) <<< (29 - frac_bits);
		return (v + half) >>> (30 - frac_bits);
	endfunction

	function automatic longint atan_fix(int idx, int frac_bits);
		return q30_to_fix(ATAN_Q30[idx], frac_bits);
	endfunction

	typedef enum logic [2:0] {
		CD_IDLE,
		CD_REDUCE,
		CD_FOLD,
		CD_ROTATE,
		CD_DONE
	} cd_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIG,
		ST_TRIG_K,
		ST_MUL_R,
		ST_RADIUS,
		ST_MUL_X,
		ST_MUL_Y,
		ST_PLACE_Y,
		ST_OUT
	} seq_state_t;

endpackage

// ===== src/pcpg_mul.sv =====
module pcpg_mul #(
	parameter int A_W = 29,
	parameter int B_W = 18
) (
	input  logic                     clk,
	input  logic signed [A_W-1:0]    op_a,
	input  logic signed [B_W-1:0]    op_b,
	output logic signed [A_W+B_W-1:0] prod
);

	logic signed [A_W+B_W-1:0] prod_q;

	// Signed product, registered so the next operation starts from a flop.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

// ===== src/pcpg_cordic.sv =====
module pcpg_cordic #(
	parameter int FULL_TURN = 411774,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [$clog2(3*FULL_TURN)-1:0]    angle,
	output logic                              done,
	output logic signed [FRAC_BITS+1:0]       cos_val,
	output logic signed [FRAC_BITS+1:0]       sin_val
);

	localparam int HALF_TURN    = FULL_TURN / 2;
	localparam int QUARTER_TURN = FULL_TURN / 4;
	localparam int ANG_W        = $clog2(3*FULL_TURN);
	localparam int TH_W         = $clog2(FULL_TURN);
	localparam int XY_W         = FRAC_BITS + 2;
	localparam int Z_W          = ((TH_W > FRAC_BITS + 1) ? TH_W : FRAC_BITS + 1) + 1;
	localparam int IT_W         = $clog2(FRAC_BITS);

	localparam logic [ANG_W-1:0] FULL_A    = ANG_W'(FULL_TURN);
	localparam logic [ANG_W-1:0] HALF_A    = ANG_W'(HALF_TURN);
	localparam logic [ANG_W-1:0] QUARTER_A = ANG_W'(QUARTER_TURN);
	localparam logic signed [Z_W-1:0]  HALF_Z = Z_W'(HALF_TURN);
	localparam logic signed [XY_W-1:0] GAIN   =
		XY_W'(pcpg_pkg::q30_to_fix(pcpg_pkg::CORDIC_GAIN_Q30, FRAC_BITS));
	localparam logic [IT_W-1:0] LAST_IT = IT_W'(FRAC_BITS - 1);

	pcpg_pkg::cd_state_t state_q, state_n;

	logic [ANG_W-1:0]       ang_q;
	logic                   neg_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [IT_W-1:0]        it_q;

	logic [ANG_W-1:0]       ang_half;
	logic                   neg_half;
	logic signed [XY_W-1:0] shift_x, shift_y;
	logic signed [Z_W-1:0]  atan_v;

	always_comb begin
		state_n = state_q;
		case (state_q)
			pcpg_pkg::CD_IDLE: begin
				if (start) state_n = pcpg_pkg::CD_REDUCE;
			end
			pcpg_pkg::CD_REDUCE: begin
				if (ang_q < FULL_A) state_n = pcpg_pkg::CD_FOLD;
			end
			pcpg_pkg::CD_FOLD: begin
				state_n = pcpg_pkg::CD_ROTATE;
			end
			pcpg_pkg::CD_ROTATE: begin
				if (it_q == LAST_IT) state_n = pcpg_pkg::CD_DONE;
			end
			pcpg_pkg::CD_DONE: begin
				state_n = start ? pcpg_pkg::CD_REDUCE : pcpg_pkg::CD_IDLE;
			end
			default: state_n = pcpg_pkg::CD_IDLE;
		endcase
	end

	always_comb begin
		done    = (state_q == pcpg_pkg::CD_DONE);
		cos_val = neg_q ? -x_q : x_q;
		sin_val = neg_q ? -y_q : y_q;
	end

	// Fold into the right half plane; a negated result undoes each half-turn shift.
	always_comb begin
		ang_half = (ang_q >= HALF_A) ? ang_q - HALF_A : ang_q;
		neg_half = (ang_q >= HALF_A);
		shift_x  = x_q >>> it_q;
		shift_y  = y_q >>> it_q;
		atan_v   = Z_W'(pcpg_pkg::atan_fix(int'(it_q), FRAC_BITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcpg_pkg::CD_IDLE;
			it_q    <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == pcpg_pkg::CD_FOLD) begin
				it_q <= '0;
			end else if (state_q == pcpg_pkg::CD_ROTATE) begin
				it_q <= it_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pcpg_pkg::CD_IDLE, pcpg_pkg::CD_DONE: begin
				if (start) ang_q <= angle;
			end
			pcpg_pkg::CD_REDUCE: begin
				if (ang_q >= FULL_A) ang_q <= ang_q - FULL_A;
			end
			pcpg_pkg::CD_FOLD: begin
				x_q <= GAIN;
				y_q <= '0;
				if (ang_half > QUARTER_A) begin
					z_q   <= Z_W'(ang_half) - HALF_Z;
					neg_q <= !neg_half;
				end else begin
					z_q   <= Z_W'(ang_half);
					neg_q <= neg_half;
				end
			end
			pcpg_pkg::CD_ROTATE: begin
				if (!z_q[Z_W-1]) begin
					x_q <= x_q - shift_y;
					y_q <= y_q + shift_x;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + shift_y;
					y_q <= y_q - shift_x;
					z_q <= z_q + atan_v;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/polar_curve_point_generator.sv =====
// Polar curve point generator. Each accepted input item produces one point of a polar curve
// (limacon, cardioid, three- or four-leaf rose, or spiral) at an angle that advances by
// angle_step per item, starting again at the first angle when restart is set or after the
// flagged last point of a turn; an item whose angle would reach a full turn produces no point
// and rewinds the curve. All work goes through one iterative CORDIC unit (one rotation per
// cycle) and one registered signed multiplier under a small sequencer, so the block takes one
// item at a time: limacon, cardioid and spiral make one CORDIC pass and a radius product,
// unknown kinds skip the radius product, and the roses need a second CORDIC pass for the
// multiple angle. A finished point waits in the output register, and the next item is
// taken meanwhile. Configuration registers are written through cfg_we, cfg_index and
// cfg_data and should be changed only while the block is idle; coordinates saturate to
// the 12-bit signed range.
module polar_curve_point_generator #(
	parameter int FULL_TURN       = 411774,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pcpg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pcpg_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   restart,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [pcpg_pkg::PIX_W-1:0]      point_x,
	output logic signed [pcpg_pkg::PIX_W-1:0]      point_y,
	output logic                                   last_point
);

	localparam int F      = ANGLE_FRAC_BITS;
	localparam int TH_W   = $clog2(FULL_TURN);
	localparam int ANG_W  = $clog2(3*FULL_TURN);
	localparam int T_W    = F + 2;
	// The radius must hold both the limacon (about a * 2^(F+3)) and the spiral (a * theta).
	localparam int R_W    = (F + 13 > TH_W + 10) ? F + 13 : TH_W + 10;
	localparam int P_W    = R_W + T_W;
	localparam int RND_SH = 2*F + 2;
	localparam int V_W    = R_W - F + 1;

	localparam int PIX_W  = pcpg_pkg::PIX_W;
	localparam int KIND_W = pcpg_pkg::KIND_W;
	localparam int COEF_W = pcpg_pkg::COEF_W;
	localparam int CTR_W  = pcpg_pkg::CTR_W;
	localparam int STEP_W = pcpg_pkg::STEP_W;

	localparam logic [TH_W:0]          FULL_T = (TH_W+1)'(FULL_TURN);
	localparam logic signed [V_W-1:0]  V_MAX  = V_W'(pcpg_pkg::PIX_MAX);
	localparam logic signed [V_W-1:0]  V_MIN  = V_W'(pcpg_pkg::PIX_MIN);

	// Configuration registers.
	logic [KIND_W-1:0] kind_q;
	logic [COEF_W-1:0] radius_a_q;
	logic [COEF_W-1:0] offset_b_q;
	logic [CTR_W-1:0]  center_x_q;
	logic [CTR_W-1:0]  center_y_q;
	logic [STEP_W-1:0] step_q;

	pcpg_pkg::seq_state_t state_q, state_n;

	// Angle of the last emitted point; zero means the next item starts a new turn.
	logic [TH_W-1:0] prev_q;
	logic [TH_W-1:0] theta_q;
	logic            last_q;

	logic signed [T_W-1:0]   c_q, s_q;
	logic signed [R_W-1:0]   r_q;
	logic signed [PIX_W-1:0] px_q, py_q;

	logic                    out_valid_q;
	logic signed [PIX_W-1:0] out_x_q, out_y_q;
	logic                    out_last_q;

	// Next angle and its checks.
	logic [TH_W-1:0] base;
	logic [TH_W:0]   theta_n;
	logic [TH_W+1:0] next_n;
	logic            theta_ok;
	logic            last_n;

	// Shared unit handshakes and operands.
	logic                  trig_start;
	logic [ANG_W-1:0]      trig_angle;
	logic                  trig_done;
	logic signed [T_W-1:0] trig_cos, trig_sin;
	logic signed [R_W-1:0] mul_a;
	logic signed [T_W-1:0] mul_b;
	logic signed [P_W-1:0] prod;

	logic [ANG_W-1:0]      ang2, ang3;
	logic signed [R_W-1:0] prod_r, bias, r_n;
	logic [COEF_W-1:0]     bias_coef;
	logic                  out_free;

	// Round the product half up, drop the fraction, add the center and saturate.
	function automatic logic signed [PIX_W-1:0] place(logic [CTR_W-1:0] ctr,
			logic signed [P_W-1:0] p);
		logic signed [P_W:0]   pr;
		logic signed [V_W-1:0] v;
		pr = (P_W+1)'(p) + ((P_W+1)'(1) <<< (RND_SH - 1));
		v  = V_W'(pr >>> RND_SH) + V_W'($signed({1'b0, ctr}));
		if (v > V_MAX) begin
			v = V_MAX;
		end else if (v < V_MIN) begin
			v = V_MIN;
		end
		return PIX_W'(v);
	endfunction

	always_comb begin
		base     = (restart || prev_q == '0) ? '0 : prev_q;
		theta_n  = (TH_W+1)'(base) + (TH_W+1)'(step_q);
		next_n   = (TH_W+2)'(theta_n) + (TH_W+2)'(step_q);
		theta_ok = (theta_n < FULL_T);
		last_n   = (next_n >= (TH_W+2)'(FULL_TURN));
		ang2     = ANG_W'(theta_q) << 1;
		ang3     = ang2 + ANG_W'(theta_q);
		out_free = !out_valid_q || out_ready;
	end

	// The cardioid is the limacon with the offset tied to the main radius.
	always_comb begin
		prod_r    = R_W'(prod);
		bias_coef = (kind_q == pcpg_pkg::KIND_CARDIOID) ? radius_a_q : offset_b_q;
		bias      = R_W'(bias_coef) << F;
		case (kind_q)
			pcpg_pkg::KIND_LIMACON, pcpg_pkg::KIND_CARDIOID: r_n = (prod_r + bias) <<< 2;
			pcpg_pkg::KIND_ROSE3, pcpg_pkg::KIND_ROSE4:      r_n = prod_r <<< 2;
			pcpg_pkg::KIND_SPIRAL:                           r_n = prod_r;
			default:                                         r_n = '0;
		endcase
	end

	// Sequencer: next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			pcpg_pkg::ST_IDLE: begin
				if (in_valid && theta_ok) state_n = pcpg_pkg::ST_TRIG;
			end
			pcpg_pkg::ST_TRIG: begin
				if (trig_done) begin
					case (kind_q)
						pcpg_pkg::KIND_ROSE3, pcpg_pkg::KIND_ROSE4:
							state_n = pcpg_pkg::ST_TRIG_K;
						pcpg_pkg::KIND_LIMACON, pcpg_pkg::KIND_CARDIOID,
						pcpg_pkg::KIND_SPIRAL:
							state_n = pcpg_pkg::ST_MUL_R;
						default:
							state_n = pcpg_pkg::ST_MUL_X;
					endcase
				end
			end
			pcpg_pkg::ST_TRIG_K: begin
				if (trig_done) state_n = pcpg_pkg::ST_MUL_R;
			end
			pcpg_pkg::ST_MUL_R:   state_n = pcpg_pkg::ST_RADIUS;
			pcpg_pkg::ST_RADIUS:  state_n = pcpg_pkg::ST_MUL_X;
			pcpg_pkg::ST_MUL_X:   state_n = pcpg_pkg::ST_MUL_Y;
			pcpg_pkg::ST_MUL_Y:   state_n = pcpg_pkg::ST_PLACE_Y;
			pcpg_pkg::ST_PLACE_Y: state_n = pcpg_pkg::ST_OUT;
			pcpg_pkg::ST_OUT: begin
				if (out_free) state_n = pcpg_pkg::ST_IDLE;
			end
			default: state_n = pcpg_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: handshake, CORDIC start and multiplier operand selection.
	always_comb begin
		in_ready   = (state_q == pcpg_pkg::ST_IDLE);
		trig_start = 1'b0;
		trig_angle = ANG_W'(theta_n);
		mul_a      = r_q;
		mul_b      = s_q;
		case (state_q)
			pcpg_pkg::ST_IDLE: begin
				trig_start = in_valid && theta_ok;
			end
			pcpg_pkg::ST_TRIG: begin
				if (kind_q == pcpg_pkg::KIND_ROSE3) begin
					trig_start = trig_done;
					trig_angle = ang3;
				end else if (kind_q == pcpg_pkg::KIND_ROSE4) begin
					trig_start = trig_done;
					trig_angle = ang2;
				end
			end
			pcpg_pkg::ST_MUL_R: begin
				if (kind_q == pcpg_pkg::KIND_SPIRAL) begin
					mul_a = R_W'(theta_q);
					mul_b = T_W'(radius_a_q);
				end else if (kind_q == pcpg_pkg::KIND_ROSE3 ||
						kind_q == pcpg_pkg::KIND_ROSE4) begin
					mul_a = R_W'(radius_a_q);
					mul_b = trig_cos;
				end else begin
					mul_a = R_W'(radius_a_q);
					mul_b = c_q;
				end
			end
			pcpg_pkg::ST_MUL_X: begin
				mul_b = c_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= pcpg_pkg::RST_CURVE_KIND;
			radius_a_q  <= pcpg_pkg::RST_RADIUS_A;
			offset_b_q  <= pcpg_pkg::RST_OFFSET_B;
			center_x_q  <= pcpg_pkg::RST_CENTER_X;
			center_y_q  <= pcpg_pkg::RST_CENTER_Y;
			step_q      <= pcpg_pkg::RST_ANGLE_STEP;
			state_q     <= pcpg_pkg::ST_IDLE;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pcpg_pkg::CFG_CURVE_KIND: kind_q     <= cfg_data[KIND_W-1:0];
					pcpg_pkg::CFG_RADIUS_A:   radius_a_q <= cfg_data[COEF_W-1:0];
					pcpg_pkg::CFG_OFFSET_B:   offset_b_q <= cfg_data[COEF_W-1:0];
					pcpg_pkg::CFG_CENTER_X:   center_x_q <= cfg_data[CTR_W-1:0];
					pcpg_pkg::CFG_CENTER_Y:   center_y_q <= cfg_data[CTR_W-1:0];
					pcpg_pkg::CFG_ANGLE_STEP: step_q     <= cfg_data[STEP_W-1:0];
					default: begin
					end
				endcase
			end

			state_q <= state_n;

			// An item whose angle reaches a full turn makes no point and rewinds the curve.
			if (state_q == pcpg_pkg::ST_IDLE && in_valid) begin
				if (!theta_ok || last_n) begin
					prev_q <= '0;
				end else begin
					prev_q <= theta_n[TH_W-1:0];
				end
			end

			if (state_q == pcpg_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pcpg_pkg::ST_IDLE: begin
				theta_q <= theta_n[TH_W-1:0];
				last_q  <= last_n;
			end
			pcpg_pkg::ST_TRIG: begin
				if (trig_done) begin
					c_q <= trig_cos;
					s_q <= trig_sin;
					r_q <= '0;
				end
			end
			pcpg_pkg::ST_RADIUS: begin
				r_q <= r_n;
			end
			pcpg_pkg::ST_MUL_Y: begin
				px_q <= place(center_x_q, prod);
			end
			pcpg_pkg::ST_PLACE_Y: begin
				py_q <= place(center_y_q, prod);
			end
			pcpg_pkg::ST_OUT: begin
				if (out_free) begin
					out_x_q    <= px_q;
					out_y_q    <= py_q;
					out_last_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	pcpg_cordic #(
		.FULL_TURN (FULL_TURN),
		.FRAC_BITS (F)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (trig_start),
		.angle   (trig_angle),
		.done    (trig_done),
		.cos_val (trig_cos),
		.sin_val (trig_sin)
	);

	pcpg_mul #(
		.A_W (R_W),
		.B_W (T_W)
	) u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	assign out_valid  = out_valid_q;
	assign point_x    = out_x_q;
	assign point_y    = out_y_q;
	assign last_point = out_last_q;

endmodule
